// ===== sv/lj_pair_force_defines.svh =====
// Assertion macros for the pair force block.
// Taken in by the top level only; expects clk and arst_n in scope.
`ifndef LJ_PAIR_FORCE_DEFINES_SVH
`define LJ_PAIR_FORCE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define LJPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pair force assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LJPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pair force assertion failed");

`endif

// ===== sv/ljpf_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair force block.
// Used by ljpf_div and lj_pair_force; depends on nothing.
package ljpf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIV_W = 96 + FRAC_BITS;
	localparam int DIV_CW = $clog2(DIV_W + 1);
	localparam int Q_NBITS = 64 + FRAC_BITS;
	localparam logic [63:0] LIM_U = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FOUR_Q = 64'd4 << FRAC_BITS;
	localparam logic [63:0] TWENTYFOUR_Q = 64'd24 << FRAC_BITS;

	localparam logic [2:0] CFG_WRAP = 3'd0;
	localparam logic [2:0] CFG_FORCE = 3'd1;
	localparam logic [2:0] CFG_BOX_X = 3'd2;
	localparam logic [2:0] CFG_BOX_Y = 3'd3;
	localparam logic [2:0] CFG_BOX_Z = 3'd4;
	localparam logic [2:0] CFG_CUTOFF = 3'd5;
	localparam logic [2:0] CFG_LOG = 3'd6;

	typedef struct packed {
		logic signed [31:0] pos_i_x;
		logic signed [31:0] pos_i_y;
		logic signed [31:0] pos_i_z;
		logic signed [31:0] pos_j_x;
		logic signed [31:0] pos_j_y;
		logic signed [31:0] pos_j_z;
		logic [31:0]        well_depth;
		logic [31:0]        zero_radius;
		logic [15:0]        step_index;
		logic               first_pair;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] pair_energy;
		logic signed [47:0] energy_sum;
		logic               in_range;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DIV_CW-1:0] nbits;
		logic [DIV_W-1:0]  dividend;
		logic [63:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [63:0]      rem;
	} div_rsp_t;

endpackage

// ===== sv/ljpf_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// Depends on ljpf_pkg for the request and response types.
module ljpf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ljpf_pkg::div_req_t req,
	output ljpf_pkg::div_rsp_t rsp
);

	logic [ljpf_pkg::DIV_W-1:0]  dvd_q;
	logic [ljpf_pkg::DIV_W-1:0]  quot_q;
	logic [63:0]                 dsr_q;
	logic [63:0]                 rem_q;
	logic [ljpf_pkg::DIV_CW-1:0] cnt_q;
	logic                        done_q;
	logic                        zero_q;
	logic                        nz_q;
	logic [64:0]                 rem_sh;
	logic                        ge;
	logic [64:0]                 rem_nx;

	assign rem_sh = {rem_q, dvd_q[ljpf_pkg::DIV_W-1]};
	assign ge = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q <= '0;
			quot_q <= '0;
			dsr_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			nz_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q <= req.dividend;
				dsr_q <= req.divisor;
				cnt_q <= req.nbits;
				rem_q <= '0;
				quot_q <= '0;
				zero_q <= req.divisor == 64'd0;
				nz_q <= req.dividend != '0;
			end else if (cnt_q != '0) begin
				dvd_q <= {dvd_q[ljpf_pkg::DIV_W-2:0], 1'b0};
				rem_q <= rem_nx[63:0];
				quot_q <= {quot_q[ljpf_pkg::DIV_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ljpf_pkg::DIV_CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// A zero divisor saturates the quotient unless the dividend is zero too.
	assign rsp.done = done_q;
	assign rsp.quot = zero_q ? {ljpf_pkg::DIV_W{nz_q}} : quot_q;
	assign rsp.rem = rem_q;

endmodule

// ===== sv/lj_pair_force.sv =====
// Lennard-Jones pair force with truncated-shifted energy, one pair per word.
// The time from an accepted pair word to a valid result is shortest out of range, longer
// in range and longest in range on a logging step; serial division and multiplication set it.
// The next word is taken in the cycle after the result is registered; res_stall delays the registering.
// Reset is asynchronous: registers go to their defaults and the energy total to zero.
// Depends on ljpf_pkg, ljpf_div and lj_pair_force_defines.svh.
`include "lj_pair_force_defines.svh"
module lj_pair_force (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pair_valid,
	output logic            pair_stall,
	input  ljpf_pkg::pair_t pair,
	output logic            res_valid,
	input  logic            res_stall,
	output ljpf_pkg::res_t  res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_WRAP, S_SQ0, S_SQ, S_CUT, S_LOG, S_S2, S_Q, S_F1, S_F2, S_F3,
		S_H1, S_H2, S_C0, S_C1, S_C2, S_E1, S_E2, S_FIN, S_MUL, S_DIV
	} state_t;

	state_t state_q, ret_q;

	logic        wrap_q, force_q;
	logic [30:0] box_x_q, box_y_q, box_z_q, cutoff_q;
	logic [15:0] log_int_q;

	ljpf_pkg::pair_t    in_q;
	logic signed [31:0] d_q [3];
	logic signed [31:0] fo_q [3];
	logic [1:0]         ax_q;
	logic [63:0]        r2_q, cut2_q, s2_q, qv_q, f_q, hmag_q, vmag_q;
	logic               sgn_q, hsgn_q, vsgn_q, ev_q, log_q, inr_q;
	logic signed [63:0] er_q;
	logic signed [31:0] pe_q;
	logic signed [47:0] total_q;
	ljpf_pkg::res_t     res_q;
	logic               res_valid_q;

	logic [63:0]  mul_a_q, mul_b_q, pp_s1;
	logic [2:0]   mul_cnt_q;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;

	ljpf_pkg::div_req_t div_req_q;
	ljpf_pkg::div_rsp_t div_rsp;

	ljpf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	function automatic logic [63:0] satq(input logic [127:0] p);
		logic [127-ljpf_pkg::FRAC_BITS:0] u;
		u = p[127:ljpf_pkg::FRAC_BITS];
		return (u > (128 - ljpf_pkg::FRAC_BITS)'(ljpf_pkg::LIM_U)) ? ljpf_pkg::LIM_U : u[63:0];
	endfunction

	logic signed [31:0] pi_w, pj_w, dsel, dwrap;
	logic [30:0]        box_w;
	logic signed [32:0] dw;
	logic signed [33:0] d2, bs, ds;
	logic [31:0]        dmag;
	logic [63:0]        prod_sat, quot_sat, g_mag, v_mag;
	logic signed [65:0] g_w, v_w;
	logic [65:0]        g_abs, v_abs;
	logic [31:0]        a_sel, b_sel;
	logic [127:0]       pp_sh;
	logic               comp_neg, comp_big, logstep, inr_w;
	logic signed [31:0] comp;
	logic signed [63:0] e_val;
	logic signed [64:0] pe_diff;
	logic signed [31:0] pe_w;
	logic signed [48:0] sum_w;
	logic signed [47:0] sum_sat;
	logic [15:0]        li_w;

	always_comb begin
		case (ax_q)
			2'd0: begin
				pi_w = in_q.pos_i_x;
				pj_w = in_q.pos_j_x;
				box_w = box_x_q;
			end
			2'd1: begin
				pi_w = in_q.pos_i_y;
				pj_w = in_q.pos_j_y;
				box_w = box_y_q;
			end
			default: begin
				pi_w = in_q.pos_i_z;
				pj_w = in_q.pos_j_z;
				box_w = box_z_q;
			end
		endcase
		dw = {pj_w[31], pj_w} - {pi_w[31], pi_w};
		d2 = {dw, 1'b0};
		bs = $signed({3'b000, box_w});
		if (wrap_q && d2 > bs) begin
			ds = {dw[32], dw} - bs;
		end else if (wrap_q && d2 <= -bs) begin
			ds = {dw[32], dw} + bs;
		end else begin
			ds = {dw[32], dw};
		end
		if (ds > $signed(34'h0_7FFF_FFFF)) begin
			dwrap = 32'sh7FFF_FFFF;
		end else if (ds < $signed(34'h3_8000_0000)) begin
			dwrap = 32'sh8000_0000;
		end else begin
			dwrap = ds[31:0];
		end
	end

	assign dsel = d_q[ax_q];
	assign dmag = dsel[31] ? ~dsel + 32'd1 : dsel;

	assign prod_sat = satq(acc_q);
	assign quot_sat = (div_rsp.quot > ljpf_pkg::DIV_W'(ljpf_pkg::LIM_U)) ?
		ljpf_pkg::LIM_U : div_rsp.quot[63:0];

	assign g_w = $signed({1'b0, prod_sat, 1'b0}) - $signed({2'b00, f_q});
	assign v_w = $signed({2'b00, prod_sat}) - $signed({2'b00, f_q});
	assign g_abs = g_w[65] ? -g_w : g_w;
	assign v_abs = v_w[65] ? -v_w : v_w;
	assign g_mag = (g_abs > {2'b00, ljpf_pkg::LIM_U}) ? ljpf_pkg::LIM_U : g_abs[63:0];
	assign v_mag = (v_abs > {2'b00, ljpf_pkg::LIM_U}) ? ljpf_pkg::LIM_U : v_abs[63:0];

	assign a_sel = mul_cnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
	assign b_sel = mul_cnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];

	always_comb begin
		case (sh_s1)
			2'd0:    pp_sh = {64'd0, pp_s1};
			2'd1:    pp_sh = {32'd0, pp_s1, 32'd0};
			default: pp_sh = {pp_s1, 64'd0};
		endcase
	end

	assign comp_neg = hsgn_q ^ dsel[31];
	assign comp_big = comp_neg ? (div_rsp.quot > ljpf_pkg::DIV_W'(33'h1_0000_0000 >> 1)) :
		(div_rsp.quot > ljpf_pkg::DIV_W'(32'h7FFF_FFFF));
	always_comb begin
		if (comp_neg) begin
			comp = comp_big ? 32'sh8000_0000 : -$signed(div_rsp.quot[31:0]);
		end else begin
			comp = comp_big ? 32'sh7FFF_FFFF : $signed(div_rsp.quot[31:0]);
		end
	end

	assign li_w = (log_int_q == 16'd0) ? 16'd1 : log_int_q;
	assign logstep = div_rsp.rem[15:0] == 16'd0;
	assign inr_w = force_q && (r2_q <= cut2_q);

	assign e_val = sgn_q ? -$signed(prod_sat) : $signed(prod_sat);
	assign pe_diff = {er_q[63], er_q} - {e_val[63], e_val};
	always_comb begin
		if (pe_diff > $signed(65'h0_0000_0000_7FFF_FFFF)) begin
			pe_w = 32'sh7FFF_FFFF;
		end else if (pe_diff < $signed(65'h1_FFFF_FFFF_8000_0000)) begin
			pe_w = 32'sh8000_0000;
		end else begin
			pe_w = pe_diff[31:0];
		end
		sum_w = {total_q[47], total_q} + {{17{pe_w[31]}}, pe_w};
		if (sum_w > $signed(49'h0_7FFF_FFFF_FFFF)) begin
			sum_sat = 48'sh7FFF_FFFF_FFFF;
		end else if (sum_w < $signed(49'h1_8000_0000_0000)) begin
			sum_sat = 48'sh8000_0000_0000;
		end else begin
			sum_sat = sum_w[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			wrap_q <= 1'b0;
			force_q <= 1'b1;
			box_x_q <= 31'd65536;
			box_y_q <= 31'd65536;
			box_z_q <= 31'd65536;
			cutoff_q <= 31'd65536;
			log_int_q <= 16'd1;
			in_q <= '0;
			d_q <= '{default: '0};
			fo_q <= '{default: '0};
			ax_q <= '0;
			r2_q <= '0;
			cut2_q <= '0;
			s2_q <= '0;
			qv_q <= '0;
			f_q <= '0;
			hmag_q <= '0;
			vmag_q <= '0;
			sgn_q <= 1'b0;
			hsgn_q <= 1'b0;
			vsgn_q <= 1'b0;
			ev_q <= 1'b0;
			log_q <= 1'b0;
			inr_q <= 1'b0;
			er_q <= '0;
			pe_q <= '0;
			total_q <= '0;
			res_q <= '0;
			res_valid_q <= 1'b0;
			mul_a_q <= '0;
			mul_b_q <= '0;
			pp_s1 <= '0;
			mul_cnt_q <= '0;
			sh_s1 <= '0;
			acc_q <= '0;
			div_req_q <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					ljpf_pkg::CFG_WRAP:   wrap_q <= cfg_data[0];
					ljpf_pkg::CFG_FORCE:  force_q <= cfg_data[0];
					ljpf_pkg::CFG_BOX_X:  box_x_q <= cfg_data[30:0];
					ljpf_pkg::CFG_BOX_Y:  box_y_q <= cfg_data[30:0];
					ljpf_pkg::CFG_BOX_Z:  box_z_q <= cfg_data[30:0];
					ljpf_pkg::CFG_CUTOFF: cutoff_q <= cfg_data[30:0];
					ljpf_pkg::CFG_LOG:    log_int_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (pair_valid) begin
						in_q <= pair;
						ax_q <= 2'd0;
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					d_q[ax_q] <= dwrap;
					if (ax_q == 2'd2) begin
						ax_q <= 2'd0;
						r2_q <= '0;
						state_q <= S_SQ0;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				S_SQ0: begin
					mul_a_q <= {32'd0, dmag};
					mul_b_q <= {32'd0, dmag};
					ret_q <= S_SQ;
					state_q <= S_MUL;
				end
				S_SQ: begin
					r2_q <= r2_q + acc_q[63:0];
					if (ax_q == 2'd2) begin
						mul_a_q <= {33'd0, cutoff_q};
						mul_b_q <= {33'd0, cutoff_q};
						ret_q <= S_CUT;
						state_q <= S_MUL;
					end else begin
						ax_q <= ax_q + 2'd1;
						state_q <= S_SQ0;
					end
				end
				S_CUT: begin
					cut2_q <= acc_q[63:0];
					div_req_q.start <= 1'b1;
					div_req_q.nbits <= ljpf_pkg::DIV_CW'(16);
					div_req_q.dividend <= {in_q.step_index, (ljpf_pkg::DIV_W - 16)'(0)};
					div_req_q.divisor <= {48'd0, li_w};
					ret_q <= S_LOG;
					state_q <= S_DIV;
				end
				S_LOG: begin
					log_q <= logstep;
					inr_q <= inr_w;
					fo_q <= '{default: '0};
					pe_q <= '0;
					ev_q <= 1'b0;
					if (logstep && in_q.first_pair) begin
						total_q <= '0;
					end
					if (inr_w) begin
						mul_a_q <= {32'd0, in_q.zero_radius};
						mul_b_q <= {32'd0, in_q.zero_radius};
						ret_q <= S_S2;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_S2: begin
					s2_q <= acc_q[63:0];
					div_req_q.start <= 1'b1;
					div_req_q.nbits <= ljpf_pkg::DIV_CW'(ljpf_pkg::Q_NBITS);
					div_req_q.dividend <= {acc_q[63:0],
						(ljpf_pkg::DIV_W - 64)'(0)};
					div_req_q.divisor <= r2_q;
					ret_q <= S_Q;
					state_q <= S_DIV;
				end
				S_Q: begin
					qv_q <= quot_sat;
					mul_a_q <= quot_sat;
					mul_b_q <= quot_sat;
					ret_q <= S_F1;
					state_q <= S_MUL;
				end
				S_F1: begin
					mul_a_q <= prod_sat;
					mul_b_q <= qv_q;
					ret_q <= S_F2;
					state_q <= S_MUL;
				end
				S_F2: begin
					f_q <= prod_sat;
					mul_a_q <= prod_sat;
					mul_b_q <= prod_sat;
					ret_q <= S_F3;
					state_q <= S_MUL;
				end
				S_F3: begin
					mul_b_q <= ev_q ? ljpf_pkg::FOUR_Q : ljpf_pkg::TWENTYFOUR_Q;
					if (ev_q) begin
						sgn_q <= v_w[65];
						mul_a_q <= v_mag;
						ret_q <= S_E1;
					end else begin
						sgn_q <= g_w[65];
						vsgn_q <= v_w[65];
						vmag_q <= v_mag;
						mul_a_q <= g_mag;
						ret_q <= S_H1;
					end
					state_q <= S_MUL;
				end
				S_H1: begin
					mul_a_q <= prod_sat;
					mul_b_q <= {32'd0, in_q.well_depth};
					ret_q <= S_H2;
					state_q <= S_MUL;
				end
				S_H2: begin
					hmag_q <= prod_sat;
					hsgn_q <= sgn_q;
					ax_q <= 2'd0;
					state_q <= S_C0;
				end
				S_C0: begin
					mul_a_q <= hmag_q;
					mul_b_q <= {32'd0, dmag};
					ret_q <= S_C1;
					state_q <= S_MUL;
				end
				S_C1: begin
					div_req_q.start <= 1'b1;
					div_req_q.nbits <= ljpf_pkg::DIV_CW'(ljpf_pkg::DIV_W);
					div_req_q.dividend <= {acc_q[95:0], ljpf_pkg::FRAC_BITS'(0)};
					div_req_q.divisor <= r2_q;
					ret_q <= S_C2;
					state_q <= S_DIV;
				end
				S_C2: begin
					fo_q[ax_q] <= comp;
					if (ax_q != 2'd2) begin
						ax_q <= ax_q + 2'd1;
						state_q <= S_C0;
					end else if (log_q) begin
						sgn_q <= vsgn_q;
						mul_a_q <= vmag_q;
						mul_b_q <= ljpf_pkg::FOUR_Q;
						ret_q <= S_E1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_E1: begin
					mul_a_q <= prod_sat;
					mul_b_q <= {32'd0, in_q.well_depth};
					ret_q <= S_E2;
					state_q <= S_MUL;
				end
				S_E2: begin
					if (!ev_q) begin
						er_q <= e_val;
						ev_q <= 1'b1;
						div_req_q.start <= 1'b1;
						div_req_q.nbits <= ljpf_pkg::DIV_CW'(ljpf_pkg::Q_NBITS);
						div_req_q.dividend <= {s2_q, (ljpf_pkg::DIV_W - 64)'(0)};
						div_req_q.divisor <= cut2_q;
						ret_q <= S_Q;
						state_q <= S_DIV;
					end else begin
						pe_q <= pe_w;
						total_q <= sum_sat;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_q.force_x <= fo_q[0];
						res_q.force_y <= fo_q[1];
						res_q.force_z <= fo_q[2];
						res_q.pair_energy <= pe_q;
						res_q.energy_sum <= total_q;
						res_q.in_range <= inr_q;
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (mul_cnt_q <= 3'd3) begin
						pp_s1 <= a_sel * b_sel;
						sh_s1 <= {1'b0, mul_cnt_q[1]} + {1'b0, mul_cnt_q[0]};
					end
					if (mul_cnt_q == 3'd0) begin
						acc_q <= '0;
					end else begin
						acc_q <= acc_q + pp_sh;
					end
					if (mul_cnt_q == 3'd4) begin
						mul_cnt_q <= 3'd0;
						state_q <= ret_q;
					end else begin
						mul_cnt_q <= mul_cnt_q + 3'd1;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pair_stall = state_q != S_IDLE;
	assign res_valid = res_valid_q;
	assign res = res_q;
	assign cfg_ready = 1'b1;

	`LJPF_ASSERT_NEXT(a_busy_after_word, pair_valid && !pair_stall, pair_stall)
	`LJPF_ASSERT_NOW(a_out_of_range_zero, res_valid && !res.in_range,
		res.force_x == 32'sd0 && res.force_y == 32'sd0 && res.force_z == 32'sd0 && res.pair_energy == 32'sd0)
	`LJPF_ASSERT_NOW(a_div_done_waited, div_rsp.done, state_q == S_DIV)

endmodule

// ===== tb/lj_pair_force_test.sv =====
// Self-checking testbench for lj_pair_force: random and directed atom pairs under
// several register settings, with a scoreboard that predicts each result word.
// Depends on ljpf_pkg and the lj_pair_force RTL only.
module lj_pair_force_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ljpf_pkg::*;

	class force_ledger;
		bit wrap_en, force_en;
		logic [30:0] box_x, box_y, box_z, cutoff;
		logic [15:0] log_every;
		longint energy_total;
		res_t due_forces[$];
		int errors;

		function new();
			wrap_en = 0;
			force_en = 1;
			box_x = 65536;
			box_y = 65536;
			box_z = 65536;
			cutoff = 65536;
			log_every = 1;
			energy_total = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				CFG_WRAP: wrap_en = data[0];
				CFG_FORCE: force_en = data[0];
				CFG_BOX_X: box_x = data[30:0];
				CFG_BOX_Y: box_y = data[30:0];
				CFG_BOX_Z: box_z = data[30:0];
				CFG_CUTOFF: cutoff = data[30:0];
				CFG_LOG: log_every = data[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_forces.size();
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function logic [63:0] sat_div(logic [127:0] n, logic [63:0] d);
			logic [127:0] q;
			if (d == 0)
				return (n != 0) ? LIM_U : 64'd0;
			q = n / {64'd0, d};
			return (q > {64'd0, LIM_U}) ? LIM_U : q[63:0];
		endfunction

		function logic [63:0] umul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS;
			return (p > {64'd0, LIM_U}) ? LIM_U : p[63:0];
		endfunction

		function longint smul(longint a, logic [63:0] b);
			longint c;
			logic [63:0] m;
			c = clamp(a, -longint'(LIM_U), longint'(LIM_U));
			m = umul(c < 0 ? 64'(-c) : 64'(c), b);
			return c < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint wrap_axis(longint d, logic [30:0] box);
			longint b;
			b = longint'({33'd0, box});
			if (wrap_en) begin
				if (2 * d > b)
					d = d - b;
				else if (2 * d <= -b)
					d = d + b;
			end
			return clamp(d, -longint'(64'h8000_0000), longint'(64'h7FFF_FFFF));
		endfunction

		function longint axis_force(longint h, longint d, logic [63:0] r2);
			bit neg;
			logic [63:0] mh, md, q;
			neg = (h < 0) != (d < 0);
			mh = h < 0 ? 64'(-h) : 64'(h);
			md = d < 0 ? 64'(-d) : 64'(d);
			q = sat_div(({64'd0, mh} * {64'd0, md}) << FRAC_BITS, r2);
			if (neg)
				return q > 64'h8000_0000 ? -longint'(64'h8000_0000) : -longint'(q);
			return q > 64'h7FFF_FFFF ? longint'(64'h7FFF_FFFF) : longint'(q);
		endfunction

		function void sixth(logic [63:0] s2, logic [63:0] r2, output logic [63:0] f,
				output logic [63:0] f2);
			logic [63:0] q;
			q = sat_div({64'd0, s2} << FRAC_BITS, r2);
			f = umul(umul(q, q), q);
			f2 = umul(f, f);
		endfunction

		function void note_pair(pair_t p);
			longint dx, dy, dz, g, h, er, ec, fx, fy, fz, pe;
			logic [63:0] r2, cut2, s2, f, f2, fc, fc2;
			logic [15:0] li;
			bit logstep, inr;
			res_t r;
			dx = wrap_axis(longint'($signed(p.pos_j_x)) - longint'($signed(p.pos_i_x)), box_x);
			dy = wrap_axis(longint'($signed(p.pos_j_y)) - longint'($signed(p.pos_i_y)), box_y);
			dz = wrap_axis(longint'($signed(p.pos_j_z)) - longint'($signed(p.pos_i_z)), box_z);
			r2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
			cut2 = {33'd0, cutoff} * {33'd0, cutoff};
			li = (log_every == 0) ? 16'd1 : log_every;
			logstep = (p.step_index % li) == 0;
			inr = force_en && (r2 <= cut2);
			fx = 0;
			fy = 0;
			fz = 0;
			pe = 0;
			if (logstep && p.first_pair)
				energy_total = 0;
			if (inr) begin
				s2 = {32'd0, p.zero_radius} * {32'd0, p.zero_radius};
				sixth(s2, r2, f, f2);
				g = clamp(2 * longint'(f2) - longint'(f), -longint'(LIM_U), longint'(LIM_U));
				h = smul(smul(g, TWENTYFOUR_Q), {32'd0, p.well_depth});
				fx = axis_force(h, dx, r2);
				fy = axis_force(h, dy, r2);
				fz = axis_force(h, dz, r2);
				if (logstep) begin
					sixth(s2, cut2, fc, fc2);
					er = smul(smul(longint'(f2) - longint'(f), FOUR_Q), {32'd0, p.well_depth});
					ec = smul(smul(longint'(fc2) - longint'(fc), FOUR_Q), {32'd0, p.well_depth});
					pe = clamp(er - ec, -longint'(64'h8000_0000), longint'(64'h7FFF_FFFF));
					energy_total = clamp(energy_total + pe, -longint'(64'h8000_0000_0000),
						longint'(64'h7FFF_FFFF_FFFF));
				end
			end
			r.force_x = fx[31:0];
			r.force_y = fy[31:0];
			r.force_z = fz[31:0];
			r.pair_energy = pe[31:0];
			r.energy_sum = energy_total[47:0];
			r.in_range = inr;
			due_forces.push_back(r);
		endfunction

		function void check_force(res_t got);
			res_t want;
			if (due_forces.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = due_forces.pop_front();
			if (got.force_x !== want.force_x) begin
				$display("%0t: force_x expected %h actual %h", $time, want.force_x, got.force_x);
				errors++;
			end
			if (got.force_y !== want.force_y) begin
				$display("%0t: force_y expected %h actual %h", $time, want.force_y, got.force_y);
				errors++;
			end
			if (got.force_z !== want.force_z) begin
				$display("%0t: force_z expected %h actual %h", $time, want.force_z, got.force_z);
				errors++;
			end
			if (got.pair_energy !== want.pair_energy) begin
				$display("%0t: pair_energy expected %h actual %h", $time, want.pair_energy,
					got.pair_energy);
				errors++;
			end
			if (got.energy_sum !== want.energy_sum) begin
				$display("%0t: energy_sum expected %h actual %h", $time, want.energy_sum,
					got.energy_sum);
				errors++;
			end
			if (got.in_range !== want.in_range) begin
				$display("%0t: in_range expected %b actual %b", $time, want.in_range,
					got.in_range);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pair_valid = 0;
	logic pair_stall;
	pair_t pair = '0;
	logic res_valid;
	logic res_stall = 0;
	res_t res;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	force_ledger sb = new();
	int burst_left = 0;
	int stall_mode = 0;
	int stall_ctr = 0;
	logic [15:0] cur_step = 0;
	int step_left = 0;
	logic [30:0] tb_box [3];
	logic [30:0] tb_cut = 65536;

	lj_pair_force u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair(pair),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_force(res);
		if (stall_ctr == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_ctr <= $urandom_range(50, 400);
		end else begin
			stall_ctr <= stall_ctr - 1;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 2) == 0);
			default: res_stall <= (stall_ctr % 32) < 12;
		endcase
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(bit wrap, bit frc, logic [31:0] bx, logic [31:0] by,
			logic [31:0] bz, logic [31:0] cut, logic [31:0] li);
		write_reg(CFG_WRAP, {31'd0, wrap});
		write_reg(CFG_FORCE, {31'd0, frc});
		write_reg(CFG_BOX_X, bx);
		write_reg(CFG_BOX_Y, by);
		write_reg(CFG_BOX_Z, bz);
		write_reg(CFG_CUTOFF, cut);
		write_reg(CFG_LOG, li);
		cfg_valid <= 1'b0;
		tb_box[0] = bx[30:0];
		tb_box[1] = by[30:0];
		tb_box[2] = bz[30:0];
		tb_cut = cut[30:0];
	endtask

	task automatic send_pair(pair_t p);
		pair <= p;
		pair_valid <= 1'b1;
		do @(posedge clk); while (pair_stall);
		sb.note_pair(p);
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 20);
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		pair_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic pair_t mk(int xi, int yi, int zi, int xj, int yj, int zj,
			logic [31:0] eps, logic [31:0] sig, logic [15:0] step, bit first);
		pair_t p;
		p.pos_i_x = xi;
		p.pos_i_y = yi;
		p.pos_i_z = zi;
		p.pos_j_x = xj;
		p.pos_j_y = yj;
		p.pos_j_z = zj;
		p.well_depth = eps;
		p.zero_radius = sig;
		p.step_index = step;
		p.first_pair = first;
		return p;
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		longint span;
		int off [3];
		int kind;
		span = longint'(tb_cut) * 5 / 4 + 2;
		if (span > 64'd1073741824)
			span = 64'd1073741824;
		kind = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++)
			off[a] = int'($urandom_range(0, 32'(2 * span))) - int'(span);
		p.pos_i_x = $urandom;
		p.pos_i_y = $urandom;
		p.pos_i_z = $urandom;
		p.pos_j_x = p.pos_i_x + off[0];
		p.pos_j_y = p.pos_i_y + off[1];
		p.pos_j_z = p.pos_i_z + off[2];
		if (kind == 0) begin
			p.pos_j_x = $urandom;
			p.pos_j_y = $urandom;
			p.pos_j_z = $urandom;
		end else if (kind == 1) begin
			p.pos_j_x = p.pos_j_x + ($urandom_range(0, 1) ? int'(tb_box[0]) : -int'(tb_box[0]));
			p.pos_j_y = p.pos_j_y + ($urandom_range(0, 1) ? int'(tb_box[1]) : -int'(tb_box[1]));
			p.pos_j_z = p.pos_j_z - int'(tb_box[2]);
		end
		case ($urandom_range(0, 3))
			0: p.well_depth = $urandom;
			1: p.well_depth = 0;
			default: p.well_depth = $urandom_range(32'h1000, 32'h8_0000);
		endcase
		if ($urandom_range(0, 7) == 0)
			p.zero_radius = $urandom;
		else
			p.zero_radius = $urandom_range(32'(span / 8), 32'(span));
		if (step_left == 0) begin
			cur_step = cur_step + 16'($urandom_range(1, 3));
			step_left = $urandom_range(1, 8);
			p.first_pair = 1'b1;
		end else begin
			p.first_pair = 1'b0;
		end
		step_left--;
		p.step_index = cur_step;
		if ($urandom_range(0, 9) == 0) begin
			p.step_index = 16'($urandom);
			p.first_pair = 1'($urandom);
		end
		return p;
	endfunction

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			send_pair(rand_pair());
			if (k == n / 2)
				drain();
		end
		drain();
	endtask

	initial begin
		tb_box[0] = 65536;
		tb_box[1] = 65536;
		tb_box[2] = 65536;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_pair(mk(0, 0, 0, 0, 0, 0, 32'h1_0000, 32'h8000, 0, 1));
		send_pair(mk(5, 5, 5, 5, 5, 5, 32'h1_0000, 0, 0, 0));
		send_pair(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, 16'hFFFF, 1));
		send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, '1, '1, 16'hFFFF, 0));
		send_pair(mk(0, 0, 0, 58982, 0, 0, 32'h1_0000, 58982, 2, 1));
		send_pair(mk(0, 0, 0, 32768, 0, 0, '1, '1, 2, 0));
		send_pair(mk(100, 100, 100, 101, 100, 100, 32'h1_0000, 32'h1_0000, 3, 0));
		send_pair(mk(0, 0, 0, 20000, -45000, -19660, 32'h2_0000, 40000, 4, 1));
		send_pair(mk(10, 0, 0, 0, 30000, -30000, 32'h1_8000, 50000, 16'hFFFF, 1));
		send_pair(mk(0, 0, 0, 0, 0, 65536, 32'h1_0000, 60000, 16'hFFFF, 0));
		drain();
		configure(0, 1, 65536, 65536, 65536, 0, 0);
		send_pair(mk(7, 7, 7, 7, 7, 7, 32'h1_0000, 32'h1_0000, 9, 1));
		send_pair(mk(7, 7, 7, 7, 7, 8, 32'h1_0000, 32'h1_0000, 9, 0));
		send_pair(mk(7, 7, 7, 7, 7, 7, 32'h1_0000, 0, 10, 0));
		drain();
		configure(1, 0, 32'h10_0000, 32'h10_0000, 32'h10_0000, 32'h3_0000, 65535);
		send_pair(mk(0, 0, 0, 30000, 0, 0, 32'h1_0000, 40000, 0, 1));
		send_pair(mk(0, 0, 0, 30000, 0, 0, 32'h1_0000, 40000, 65535, 1));
		drain();
		configure(1, 1, 32'h10_0000, 32'h10_0000, 32'h10_0000, 32'h3_0000, 65535);
		send_pair(mk(0, 0, 0, 32'h10_0000 - 40000, 0, 0, 32'h1_0000, 40000, 0, 1));
		send_pair(mk(0, 0, 0, 0, -(32'h10_0000 - 50000), 0, 32'h1_0000, 40000, 0, 0));
		send_pair(mk(0, 0, 0, 30000, 0, 0, 32'h1_0000, 40000, 7, 0));
		drain();

		configure(1, 1, 32'hA_0000, 32'hA_0000, 32'hA_0000, 32'h2_8000, 1);
		random_phase(230);
		configure(1, 1, $urandom_range(32'h4_0000, 32'h7FFF_FFFF), $urandom_range(32'h4_0000,
			32'h7FFF_FFFF), 32'h4_0000, 32'h3_0000, 5);
		random_phase(230);
		configure(0, 1, 0, 0, 0, 32'h7FFF_FFFF, 0);
		random_phase(150);
		configure(1, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1);
		random_phase(200);
		configure(0, 0, 65536, 65536, 65536, 32'h2_0000, 3);
		random_phase(150);
		configure(1, 1, 32'h6_0000, 32'h8_0000, 32'h7_0000, $urandom_range(32'h8000,
			32'h4_0000), $urandom_range(1, 4));
		random_phase(370);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule
